### design/key_matrix_debouncer_assert.svh
// Assertion macros for the key matrix debouncer.
// Used by key_matrix_debouncer.sv; expects a clock named clock and a reset named reset.
`ifndef KEY_MATRIX_DEBOUNCER_ASSERT_SVH
`define KEY_MATRIX_DEBOUNCER_ASSERT_SVH

// same-cycle implication
`define KMD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KMD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/kmd_pkg.sv
// Shared types and constants for the key matrix debouncer.
// No dependencies; imported by every module of the block.
`default_nettype none

package kmd_pkg;

   localparam int ROW_COUNT = 16;
   localparam int COL_COUNT = 8;

   localparam int ROW_W      = 8;   // width of a stored row word
   localparam int LEVEL_W    = 16;  // width of the sensed row levels
   localparam int COL_IDX_W  = 3;
   localparam int QROW_W     = 4;
   localparam int CNT_W      = 8;   // debounce counter and register
   localparam int TOTAL_W    = 8;   // pressed-key count
   localparam int ROW_IDX_W  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_DEBOUNCE_SCANS = 1'b0;  // register index, paddr[2]

   localparam logic [CNT_W-1:0] DEBOUNCE_RESET = CNT_W'(10);
   localparam logic [ROW_W-1:0] ROW_MASK = ROW_W'((1 << COL_COUNT) - 1);

   typedef logic [ROW_W-1:0] row_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_WALK,
      ST_FINISH
   } kmd_state_type;

   typedef struct packed {
      logic clear;
      logic step;
      logic is_query;
   } kmd_acc_ctrl_type;

   typedef struct packed {
      logic settled;
      logic bounce;
   } kmd_status_type;

   function automatic logic [3:0] ones_in(input row_type v);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < ROW_W; i++) begin
         n = n + 4'(v[i]);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

### design/key_matrix_debouncer.sv
// Top level of the key matrix debouncer: sequencer, CSR and result register.
// Depends on kmd_pkg, kmd_matrix, kmd_row_acc and key_matrix_debouncer_assert.svh.
//
//   port group  dir   handshake              word
//   req_*       in    req_valid/req_ready    column, row_levels, end_of_scan, query_row/col
//   rsp_*       out   rsp_valid/rsp_ready    row word, key, ghost, count, settled, bounce
//   csr_*       in    APB psel/penable       debounce_scans at byte address 0
//
// An item passes accept, matrix update, one row per cycle through the shared
// popcount/overlap unit, then the load of the result register.
// req_ready is high only while the sequencer is idle; a held result stalls only the load.
// Reset is synchronous and clears both matrices at once; the counter reloads to 10.
`default_nettype none
`include "key_matrix_debouncer_assert.svh"

module key_matrix_debouncer import kmd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COL_IDX_W-1:0]  req_column,
   input  logic [LEVEL_W-1:0]    req_row_levels,
   input  logic                  req_end_of_scan,
   input  logic [QROW_W-1:0]     req_query_row,
   input  logic [COL_IDX_W-1:0]  req_query_col,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ROW_W-1:0]      rsp_stable_row_word,
   output logic                  rsp_key_on,
   output logic                  rsp_ghost_in_row,
   output logic [TOTAL_W-1:0]    rsp_key_count,
   output logic                  rsp_settled,
   output logic                  rsp_bounce_seen,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   kmd_state_type        state_ff;
   kmd_state_type        state_in;
   logic [ROW_IDX_W-1:0] walk_ff;
   logic [ROW_IDX_W-1:0] walk_in;
   logic                 walk_last;
   logic                 load;
   logic                 accept;

   logic [CNT_W-1:0]     scans_ff;

   logic [COL_IDX_W-1:0] col_ff;
   logic [LEVEL_W-1:0]   levels_ff;
   logic                 eos_ff;
   logic [QROW_W-1:0]    qrow_ff;
   logic [COL_IDX_W-1:0] qcol_ff;

   row_type              rd_word;
   kmd_status_type       status;
   kmd_acc_ctrl_type     acc_ctrl;
   logic [TOTAL_W-1:0]   acc_count;
   row_type              acc_query;
   logic                 acc_ghost;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   row_type              rsp_word_ff;
   logic                 rsp_key_ff;
   logic                 rsp_ghost_ff;
   logic [TOTAL_W-1:0]   rsp_count_ff;
   logic                 rsp_settled_ff;
   logic                 rsp_bounce_ff;
   logic                 key_bit;

   // ---------------- CSR ----------------
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_DEBOUNCE_SCANS) ?
                       CSR_DATA_W'(scans_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         scans_ff <= DEBOUNCE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == CSR_IDX_DEBOUNCE_SCANS)) begin
         scans_ff <= csr_pwdata[CNT_W-1:0];
      end
   end

   // ---------------- sequencer ----------------
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign walk_last = (32'(walk_ff) == ROW_COUNT - 1);

   always_comb begin
      state_in = state_ff;
      walk_in  = walk_ff;
      load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            walk_in  = '0;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            walk_in = walk_ff + ROW_IDX_W'(1);
            if (walk_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff <= walk_in;
      if (accept) begin
         col_ff    <= req_column;
         levels_ff <= req_row_levels;
         eos_ff    <= req_end_of_scan;
         qrow_ff   <= req_query_row;
         qcol_ff   <= req_query_col;
      end
   end

   // ---------------- datapath ----------------
   kmd_matrix u_matrix (
      .clock          (clock),
      .reset          (reset),
      .apply          (state_ff == ST_UPDATE),
      .column         (col_ff),
      .row_levels     (levels_ff),
      .end_of_scan    (eos_ff),
      .debounce_scans (scans_ff),
      .rd_row         (walk_ff),
      .rd_word        (rd_word),
      .status         (status)
   );

   assign acc_ctrl.clear    = (state_ff == ST_UPDATE);
   assign acc_ctrl.step     = (state_ff == ST_WALK);
   assign acc_ctrl.is_query = (32'(walk_ff) == 32'(qrow_ff));

   kmd_row_acc u_row_acc (
      .clock      (clock),
      .ctrl       (acc_ctrl),
      .row_word   (rd_word),
      .key_count  (acc_count),
      .query_word (acc_query),
      .ghost      (acc_ghost)
   );

   assign key_bit = (32'(qcol_ff) < COL_COUNT) ? acc_query[qcol_ff] : 1'b0;

   // ---------------- result word ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_word_ff    <= acc_query;
         rsp_key_ff     <= key_bit;
         rsp_ghost_ff   <= acc_ghost;
         rsp_count_ff   <= acc_count;
         rsp_settled_ff <= status.settled;
         rsp_bounce_ff  <= status.bounce;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_stable_row_word = rsp_word_ff;
   assign rsp_key_on          = rsp_key_ff;
   assign rsp_ghost_in_row    = rsp_ghost_ff;
   assign rsp_key_count       = rsp_count_ff;
   assign rsp_settled         = rsp_settled_ff;
   assign rsp_bounce_seen     = rsp_bounce_ff;

   // ---------------- assertions ----------------
   `KMD_ASSERT_NEXT(a_accept_update, accept, state_ff == ST_UPDATE, "accepted word did not start an update")
   `KMD_ASSERT_NEXT(a_walk_finish, (state_ff == ST_WALK) && walk_last, state_ff == ST_FINISH, "row walk overran")
   `KMD_ASSERT_NEXT(a_load_valid, load, rsp_valid_ff && (state_ff == ST_IDLE), "result load lost")
   `KMD_ASSERT_IMP(a_count_range, rsp_valid_ff, 32'(rsp_count_ff) <= ROW_COUNT * COL_COUNT, "key count too large")
   `KMD_ASSERT_IMP(a_ghost_count, rsp_valid_ff && rsp_ghost_ff, rsp_count_ff >= TOTAL_W'(3), "ghost with too few keys")

endmodule

`default_nettype wire

### design/kmd_matrix.sv
// Raw and stable key matrices with the global debounce counter.
// Depends on kmd_pkg.
`default_nettype none

module kmd_matrix import kmd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 apply,
   input  logic [COL_IDX_W-1:0] column,
   input  logic [LEVEL_W-1:0]   row_levels,
   input  logic                 end_of_scan,
   input  logic [CNT_W-1:0]     debounce_scans,
   input  logic [ROW_IDX_W-1:0] rd_row,
   output row_type              rd_word,
   output kmd_status_type       status
);

   row_type          raw_ff    [ROW_COUNT];
   row_type          raw_in    [ROW_COUNT];
   row_type          stable_ff [ROW_COUNT];
   row_type          stable_in [ROW_COUNT];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             bounce_ff;
   logic             bounce_in;
   logic             changed;
   logic             col_ok;
   logic [CNT_W-1:0] reload;
   logic [CNT_W-1:0] count_mid;

   always_comb begin
      raw_in  = raw_ff;
      changed = 1'b0;
      col_ok  = (32'(column) < COL_COUNT);
      for (int r = 0; r < ROW_COUNT; r++) begin
         if (col_ok && (row_levels[r] != raw_ff[r][column])) begin
            raw_in[r][column] = row_levels[r];
            changed           = 1'b1;
         end
      end
      // zero delay behaves as one scan
      reload    = (debounce_scans == '0) ? CNT_W'(1) : debounce_scans;
      count_mid = changed ? reload : count_ff;
      count_in  = count_mid;
      stable_in = stable_ff;
      if (end_of_scan && (count_mid != '0)) begin
         count_in = count_mid - CNT_W'(1);
         if (count_in == '0) begin
            stable_in = raw_in;
         end
      end
      bounce_in = changed && (count_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff    <= '{default: '0};
         stable_ff <= '{default: '0};
         count_ff  <= DEBOUNCE_RESET;
         bounce_ff <= 1'b0;
      end else if (apply) begin
         raw_ff    <= raw_in;
         stable_ff <= stable_in;
         count_ff  <= count_in;
         bounce_ff <= bounce_in;
      end
   end

   assign rd_word        = stable_ff[rd_row] & ROW_MASK;
   assign status.settled = (count_ff == '0);
   assign status.bounce  = bounce_ff;

endmodule

`default_nettype wire

### design/kmd_row_acc.sv
// Shared row unit: one stable row per cycle into key count, query word and column overlap.
// Depends on kmd_pkg.
`default_nettype none

module kmd_row_acc import kmd_pkg::*; (
   input  logic               clock,
   input  kmd_acc_ctrl_type   ctrl,
   input  row_type            row_word,
   output logic [TOTAL_W-1:0] key_count,
   output row_type            query_word,
   output logic               ghost
);

   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W-1:0] total_in;
   row_type            query_ff;
   row_type            query_in;
   row_type            once_ff;
   row_type            once_in;
   row_type            twice_ff;
   row_type            twice_in;

   always_comb begin
      total_in = total_ff;
      query_in = query_ff;
      once_in  = once_ff;
      twice_in = twice_ff;
      if (ctrl.clear) begin
         total_in = '0;
         query_in = '0;
         once_in  = '0;
         twice_in = '0;
      end else if (ctrl.step) begin
         total_in = total_ff + TOTAL_W'(ones_in(row_word));
         once_in  = once_ff | row_word;
         // a column pressed in two or more rows
         twice_in = twice_ff | (once_ff & row_word);
         if (ctrl.is_query) begin
            query_in = row_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
      query_ff <= query_in;
      once_ff  <= once_in;
      twice_ff <= twice_in;
   end

   assign key_count  = total_ff;
   assign query_word = query_ff;
   assign ghost      = ((query_ff & (query_ff - ROW_W'(1))) != '0) &&
                       ((twice_ff & query_ff) != '0);

endmodule

`default_nettype wire
